@@ design/hsps_pkg.sv @@
`timescale 1ns / 1ps
package hsps_pkg;

    // field widths fixed by the interface, internal accumulator and calc widths
    localparam int BYTE_W   = 8;
    localparam int ERR_W    = 4;
    localparam int ACC_W    = 33;
    localparam int WIDTH_W  = 15;
    localparam int HEIGHT_W = 16;
    localparam int SAR_W    = 16;
    localparam int CALC_W   = 18;

    // default limits in macroblocks, default start code skip count in bytes
    localparam int DEF_MAX_WIDTH_MBS  = 1024;
    localparam int DEF_MAX_HEIGHT_MBS = 1024;
    localparam logic [2:0] DEF_SKIP_BYTES = 3'd4;

    // error codes
    localparam logic [ERR_W-1:0] ERR_NONE     = 4'd0;
    localparam logic [ERR_W-1:0] ERR_PROFILE  = 4'd1;
    localparam logic [ERR_W-1:0] ERR_SPS_ID   = 4'd2;
    localparam logic [ERR_W-1:0] ERR_CHROMA   = 4'd3;
    localparam logic [ERR_W-1:0] ERR_DEPTH    = 4'd4;
    localparam logic [ERR_W-1:0] ERR_FRAMENUM = 4'd5;
    localparam logic [ERR_W-1:0] ERR_POC_TYPE = 4'd6;
    localparam logic [ERR_W-1:0] ERR_POC_CYC  = 4'd7;
    localparam logic [ERR_W-1:0] ERR_REFS     = 4'd8;
    localparam logic [ERR_W-1:0] ERR_D8       = 4'd9;
    localparam logic [ERR_W-1:0] ERR_OVERSIZE = 4'd10;
    localparam logic [ERR_W-1:0] ERR_TRUNC    = 4'd11;

    // controller to datapath commands
    typedef struct packed {
        logic       load;
        logic       bit_en;
        logic [2:0] bit_sel;
        logic       emit;
    } t_ctl_cmd;

    // datapath to controller status
    typedef struct packed {
        logic feed;
    } t_dp_status;

    // sample aspect ratio table, numerator
    function automatic logic [7:0] sar_w_lookup(input logic [3:0] idx);
        logic [7:0] r;
        case (idx)
            4'd2:    r = 8'd12;
            4'd3:    r = 8'd10;
            4'd4:    r = 8'd16;
            4'd5:    r = 8'd40;
            4'd6:    r = 8'd24;
            4'd7:    r = 8'd20;
            4'd8:    r = 8'd32;
            4'd9:    r = 8'd80;
            4'd10:   r = 8'd18;
            4'd11:   r = 8'd15;
            4'd12:   r = 8'd64;
            4'd13:   r = 8'd160;
            default: r = 8'd1;
        endcase
        return r;
    endfunction

    // sample aspect ratio table, denominator
    function automatic logic [7:0] sar_h_lookup(input logic [3:0] idx);
        logic [7:0] r;
        case (idx)
            4'd2, 4'd3, 4'd4, 4'd6, 4'd7, 4'd8, 4'd10, 4'd11: r = 8'd11;
            4'd5, 4'd9, 4'd12: r = 8'd33;
            4'd13:   r = 8'd99;
            default: r = 8'd1;
        endcase
        return r;
    endfunction

endpackage

@@ design/h264_sps_header_parser.sv @@
`timescale 1ns / 1ps
// H.264 SPS header parser
// input stream: one raw NAL byte per transaction in s_axis_tdata, tlast on
//   the final byte of the unit. the first configured count of bytes (start
//   code) is ignored, emulation prevention bytes are dropped.
// output stream: one transaction per unit, issued after its last byte.
//   tuser carries header_ok, tdata the decoded fields.
// config: i_cfg_wen / i_cfg_wdata write the leading skip byte count (reset 4);
//   the user must do so only while the block is idle, which is not enforced.
// timing: a skipped or dropped byte is only accepted; a parsed byte is accepted
//   and then takes one cycle per bit in the field sequencer. after the last
//   byte the result register is loaded, which waits while an earlier result
//   has not yet been taken.
// the result register sits between the two sides: new bytes are accepted
//   while a result waits; only a second result waits for the first to drain.
// reset: synchronous active low; skip count returns to 4, parser restarts at
//   the NAL header byte, no result pending.
module h264_sps_header_parser #(
    parameter int MAX_WIDTH_MBS  = hsps_pkg::DEF_MAX_WIDTH_MBS,
    parameter int MAX_HEIGHT_MBS = hsps_pkg::DEF_MAX_HEIGHT_MBS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wen,
    input  logic [2:0]  i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // byte_value[7:0]
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // error_code[3:0], profile_code[11:4], level_code[19:12],
    // frame_width[34:20], frame_height[50:35], aspect_width[66:51],
    // aspect_height[82:67], zero pad[87:83]
    output logic [87:0] m_axis_tdata,
    output logic        m_axis_tuser    // header_ok[0]
);
    import hsps_pkg::*;

    t_ctl_cmd           cmd;
    t_dp_status         status;
    logic [ERR_W-1:0]   error_code;
    logic [BYTE_W-1:0]  profile_code;
    logic [BYTE_W-1:0]  level_code;
    logic [WIDTH_W-1:0] frame_width;
    logic [HEIGHT_W-1:0] frame_height;
    logic [SAR_W-1:0]   aspect_width;
    logic [SAR_W-1:0]   aspect_height;

    hsps_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_last   (s_axis_tlast),
        .o_in_ready  (s_axis_tready),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    hsps_datapath #(
        .MAX_WIDTH_MBS  (MAX_WIDTH_MBS),
        .MAX_HEIGHT_MBS (MAX_HEIGHT_MBS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wen       (i_cfg_wen),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_byte          (s_axis_tdata),
        .i_cmd           (cmd),
        .o_status        (status),
        .o_header_ok     (m_axis_tuser),
        .o_error_code    (error_code),
        .o_profile_code  (profile_code),
        .o_level_code    (level_code),
        .o_frame_width   (frame_width),
        .o_frame_height  (frame_height),
        .o_aspect_width  (aspect_width),
        .o_aspect_height (aspect_height)
    );

    // output packing
    assign m_axis_tdata = {5'd0, aspect_height, aspect_width, frame_height,
                           frame_width, level_code, profile_code, error_code};

    // header_ok agrees with the error code
    a_ok_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser == (m_axis_tdata[3:0] == ERR_NONE)))
        else $error("header_ok does not match error code");

    // failed header gives zero size and unit aspect
    a_err_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser) |->
            (m_axis_tdata[50:20] == '0 && m_axis_tdata[66:51] == 16'd1 &&
             m_axis_tdata[82:67] == 16'd1))
        else $error("error result carries decoded fields");

    // a non-last byte never produces a result in the next cycle
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && !s_axis_tlast && !m_axis_tvalid)
            |=> !m_axis_tvalid)
        else $error("result without a last byte");

endmodule

@@ design/hsps_ctrl.sv @@
`timescale 1ns / 1ps
module hsps_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_last,
    output logic                o_in_ready,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    input  hsps_pkg::t_dp_status i_status,
    output hsps_pkg::t_ctl_cmd   o_cmd
);
    import hsps_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_BITS, S_EMIT} t_state;

    t_state     r_state;
    logic [2:0] r_cnt;
    logic       r_last;
    logic       r_out_valid;
    logic       accept;
    logic       emit;

    // handshake decode
    assign o_in_ready  = (r_state == S_IDLE);
    assign accept      = i_in_valid && o_in_ready;
    assign emit        = (r_state == S_EMIT) && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;

    // commands to datapath
    always_comb begin
        o_cmd.load    = accept;
        o_cmd.bit_en  = (r_state == S_BITS);
        o_cmd.bit_sel = r_cnt;
        o_cmd.emit    = emit;
    end

    // sequencer and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= 3'd7;
            r_last      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_last <= i_in_last;
                        r_cnt  <= 3'd7;
                        if (i_status.feed) begin
                            r_state <= S_BITS;
                        end else if (i_in_last) begin
                            r_state <= S_EMIT;
                        end
                    end
                end
                S_BITS: begin
                    if (r_cnt == 3'd0) begin
                        r_state <= r_last ? S_EMIT : S_IDLE;
                    end else begin
                        r_cnt <= r_cnt - 3'd1;
                    end
                end
                S_EMIT: begin
                    if (emit) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

@@ design/hsps_datapath.sv @@
`timescale 1ns / 1ps
module hsps_datapath #(
    parameter int MAX_WIDTH_MBS  = hsps_pkg::DEF_MAX_WIDTH_MBS,
    parameter int MAX_HEIGHT_MBS = hsps_pkg::DEF_MAX_HEIGHT_MBS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wen,
    input  logic [2:0]                    i_cfg_wdata,
    input  logic [hsps_pkg::BYTE_W-1:0]   i_byte,
    input  hsps_pkg::t_ctl_cmd            i_cmd,
    output hsps_pkg::t_dp_status          o_status,
    output logic                          o_header_ok,
    output logic [hsps_pkg::ERR_W-1:0]    o_error_code,
    output logic [hsps_pkg::BYTE_W-1:0]   o_profile_code,
    output logic [hsps_pkg::BYTE_W-1:0]   o_level_code,
    output logic [hsps_pkg::WIDTH_W-1:0]  o_frame_width,
    output logic [hsps_pkg::HEIGHT_W-1:0] o_frame_height,
    output logic [hsps_pkg::SAR_W-1:0]    o_aspect_width,
    output logic [hsps_pkg::SAR_W-1:0]    o_aspect_height
);
    import hsps_pkg::*;

    localparam int WU_W = $clog2(MAX_WIDTH_MBS);
    localparam int HU_W = $clog2(MAX_HEIGHT_MBS);

    typedef enum logic [5:0] {
        PH_NAL, PH_PROFILE, PH_CONSTR, PH_LEVEL, PH_SPS_ID, PH_CHROMA, PH_SEP,
        PH_DEPTH_L, PH_DEPTH_C, PH_BYPASS, PH_SM_FLAG, PH_SL_FLAG, PH_DELTA,
        PH_FRAME_NUM, PH_POC_TYPE, PH_POC_LSB, PH_POC_ZERO, PH_POC_NONREF,
        PH_POC_TB, PH_POC_CYCLE, PH_POC_OFFSET, PH_REFS, PH_GAPS, PH_WIDTH,
        PH_HEIGHT, PH_FMO, PH_MBAFF, PH_D8, PH_CROP_FLAG, PH_CROP_L, PH_CROP_R,
        PH_CROP_T, PH_CROP_B, PH_VUI, PH_AR_FLAG, PH_AR_IDC, PH_SAR_W, PH_SAR_H,
        PH_DONE
    } t_phase;

    // fixed field length, zero for exp-golomb
    function automatic logic [4:0] field_len(input t_phase ph);
        logic [4:0] r;
        case (ph)
            PH_NAL, PH_PROFILE, PH_CONSTR, PH_LEVEL, PH_AR_IDC: r = 5'd8;
            PH_SAR_W, PH_SAR_H: r = 5'd16;
            PH_SEP, PH_BYPASS, PH_SM_FLAG, PH_SL_FLAG, PH_POC_ZERO, PH_GAPS,
            PH_FMO, PH_MBAFF, PH_D8, PH_CROP_FLAG, PH_VUI, PH_AR_FLAG: r = 5'd1;
            default: r = 5'd0;
        endcase
        return r;
    endfunction

    logic [2:0]        r_cfg;
    logic [7:0]        r_byte;
    logic [2:0]        r_skip;
    logic [1:0]        r_zrun;
    t_phase            r_phase,   n_phase;
    logic [5:0]        r_lz,      n_lz;
    logic [ACC_W-1:0]  r_acc,     n_acc;
    logic [5:0]        r_bcnt,    n_bcnt;
    logic              r_suf,     n_suf;
    logic [3:0]        r_list,    n_list;
    logic [7:0]        r_entry,   n_entry;
    logic [7:0]        r_last_sc, n_last_sc;
    logic [7:0]        r_next_sc, n_next_sc;
    logic [1:0]        r_chroma,  n_chroma;
    logic              r_fonly,   n_fonly;
    logic [WU_W-1:0]   r_wu,      n_wu;
    logic [HU_W-1:0]   r_hu,      n_hu;
    logic [15:0]       r_crop_r,  n_crop_r;
    logic [15:0]       r_crop_b,  n_crop_b;
    logic [7:0]        r_prof,    n_prof;
    logic [7:0]        r_lvl,     n_lvl;
    logic [15:0]       r_aw,      n_aw;
    logic [15:0]       r_ah,      n_ah;
    logic [ERR_W-1:0]  r_err,     n_err;

    logic              bit_in;
    logic              done;
    logic [ACC_W-1:0]  v;
    logic [ACC_W-1:0]  acc_sh;
    logic [4:0]        len;
    logic [5:0]        cnt_inc;
    logic [ACC_W:0]    v_inc;
    logic [7:0]        mag8;
    logic [7:0]        sc_new;
    logic [7:0]        ent_inc;
    logic [6:0]        list_size;
    logic [3:0]        list_inc;
    logic              list_more;
    logic [CALC_W-1:0] h_mbs;

    logic              skip_now;
    logic              drop_now;

    // byte framing: skipped start code and emulation prevention
    assign skip_now      = (r_skip < r_cfg);
    assign drop_now      = !skip_now && (r_zrun == 2'd2) && (i_byte == 8'h03);
    assign o_status.feed = !skip_now && !drop_now;

    // one bit of the field sequencer
    always_comb begin
        n_phase = r_phase;  n_lz = r_lz;  n_acc = r_acc;  n_bcnt = r_bcnt;
        n_suf = r_suf;  n_list = r_list;  n_entry = r_entry;
        n_last_sc = r_last_sc;  n_next_sc = r_next_sc;  n_chroma = r_chroma;
        n_fonly = r_fonly;  n_wu = r_wu;  n_hu = r_hu;  n_crop_r = r_crop_r;
        n_crop_b = r_crop_b;  n_prof = r_prof;  n_lvl = r_lvl;  n_aw = r_aw;
        n_ah = r_ah;  n_err = r_err;
        bit_in    = r_byte[i_cmd.bit_sel];
        done      = 1'b0;
        v         = '0;
        len       = field_len(r_phase);
        acc_sh    = {r_acc[ACC_W-2:0], bit_in};
        cnt_inc   = r_bcnt + 6'd1;
        v_inc     = '0;
        mag8      = '0;
        sc_new    = '0;
        ent_inc   = r_entry + 8'd1;
        list_size = (r_list < 4'd6) ? 7'd16 : 7'd64;
        list_inc  = r_list + 4'd1;
        list_more = (list_inc < ((r_chroma != 2'd3) ? 4'd8 : 4'd12));
        h_mbs     = (CALC_W'(r_hu) + CALC_W'(1)) << (r_fonly ? 0 : 1);

        if (r_phase != PH_DONE) begin
            // gather bits of the current field
            if (len == 5'd0) begin
                if (!r_suf) begin
                    if (!bit_in) begin
                        if (r_lz < 6'd32) begin
                            n_lz = r_lz + 6'd1;
                        end
                    end else begin
                        n_suf  = 1'b1;
                        n_acc  = ACC_W'(1);
                        n_bcnt = r_lz;
                        if (r_lz == 6'd0) begin
                            done = 1'b1;
                        end
                    end
                end else begin
                    n_acc  = acc_sh;
                    n_bcnt = r_bcnt - 6'd1;
                    if (r_bcnt == 6'd1) begin
                        done = 1'b1;
                        v    = acc_sh - ACC_W'(1);
                    end
                end
            end else begin
                n_acc  = acc_sh;
                n_bcnt = cnt_inc;
                if (cnt_inc >= 6'(len)) begin
                    done = 1'b1;
                    v    = acc_sh;
                end
            end
        end

        // act on a finished field
        if (done) begin
            n_acc = '0;  n_bcnt = '0;  n_lz = '0;  n_suf = 1'b0;
            v_inc = {1'b0, v} + (ACC_W+1)'(1);
            mag8  = v_inc[8:1];
            case (r_phase)
                PH_NAL: n_phase = PH_PROFILE;
                PH_PROFILE: begin
                    n_prof = v[7:0];
                    if (v != 66 && v != 77 && v != 88 && v != 100 && v != 110 &&
                        v != 122 && v != 244 && v != 44) begin
                        n_err = ERR_PROFILE;  n_phase = PH_DONE;
                    end else begin
                        n_phase = PH_CONSTR;
                    end
                end
                PH_CONSTR: n_phase = PH_LEVEL;
                PH_LEVEL: begin
                    n_lvl = v[7:0];  n_phase = PH_SPS_ID;
                end
                PH_SPS_ID: begin
                    if (v >= 32) begin
                        n_err = ERR_SPS_ID;  n_phase = PH_DONE;
                    end else if (r_prof >= 8'd100 || r_prof == 8'd44) begin
                        n_phase = PH_CHROMA;
                    end else begin
                        n_chroma = 2'd1;  n_phase = PH_FRAME_NUM;
                    end
                end
                PH_CHROMA: begin
                    if (v > 3) begin
                        n_err = ERR_CHROMA;  n_phase = PH_DONE;
                    end else begin
                        n_chroma = v[1:0];
                        n_phase  = (v == 3) ? PH_SEP : PH_DEPTH_L;
                    end
                end
                PH_SEP: n_phase = PH_DEPTH_L;
                PH_DEPTH_L, PH_DEPTH_C: begin
                    if (v > 4) begin
                        n_err = ERR_DEPTH;  n_phase = PH_DONE;
                    end else begin
                        n_phase = (r_phase == PH_DEPTH_L) ? PH_DEPTH_C : PH_BYPASS;
                    end
                end
                PH_BYPASS: n_phase = PH_SM_FLAG;
                PH_SM_FLAG: begin
                    n_list  = '0;
                    n_phase = v[0] ? PH_SL_FLAG : PH_FRAME_NUM;
                end
                PH_SL_FLAG: begin
                    if (v[0]) begin
                        n_entry = '0;  n_last_sc = 8'd8;  n_next_sc = 8'd8;
                        n_phase = PH_DELTA;
                    end else begin
                        n_list  = list_inc;
                        n_phase = list_more ? PH_SL_FLAG : PH_FRAME_NUM;
                    end
                end
                PH_DELTA: begin
                    // a zero scale repeats the last value to the end of the list
                    sc_new    = v[0] ? (r_last_sc + mag8) : (r_last_sc - mag8);
                    n_next_sc = sc_new;
                    if (sc_new != 8'd0) begin
                        n_last_sc = sc_new;
                    end
                    n_entry = ent_inc;
                    if (ent_inc >= 8'(list_size) || sc_new == 8'd0) begin
                        n_list  = list_inc;
                        n_phase = list_more ? PH_SL_FLAG : PH_FRAME_NUM;
                    end else begin
                        n_phase = PH_DELTA;
                    end
                end
                PH_FRAME_NUM: begin
                    if (v > 12) begin
                        n_err = ERR_FRAMENUM;  n_phase = PH_DONE;
                    end else begin
                        n_phase = PH_POC_TYPE;
                    end
                end
                PH_POC_TYPE: begin
                    if (v > 2) begin
                        n_err = ERR_POC_TYPE;  n_phase = PH_DONE;
                    end else if (v == 0) begin
                        n_phase = PH_POC_LSB;
                    end else if (v == 1) begin
                        n_phase = PH_POC_ZERO;
                    end else begin
                        n_phase = PH_REFS;
                    end
                end
                PH_POC_LSB:    n_phase = PH_REFS;
                PH_POC_ZERO:   n_phase = PH_POC_NONREF;
                PH_POC_NONREF: n_phase = PH_POC_TB;
                PH_POC_TB:     n_phase = PH_POC_CYCLE;
                PH_POC_CYCLE: begin
                    if (v > 255) begin
                        n_err = ERR_POC_CYC;  n_phase = PH_DONE;
                    end else begin
                        n_entry = v[7:0];
                        n_phase = (v == 0) ? PH_REFS : PH_POC_OFFSET;
                    end
                end
                PH_POC_OFFSET: begin
                    n_entry = r_entry - 8'd1;
                    if (r_entry == 8'd1) begin
                        n_phase = PH_REFS;
                    end
                end
                PH_REFS: begin
                    if (v > 16) begin
                        n_err = ERR_REFS;  n_phase = PH_DONE;
                    end else begin
                        n_phase = PH_GAPS;
                    end
                end
                PH_GAPS: n_phase = PH_WIDTH;
                PH_WIDTH: begin
                    if (v >= ACC_W'(MAX_WIDTH_MBS)) begin
                        n_err = ERR_OVERSIZE;  n_phase = PH_DONE;
                    end else begin
                        n_wu = v[WU_W-1:0];  n_phase = PH_HEIGHT;
                    end
                end
                PH_HEIGHT: begin
                    if (v >= ACC_W'(MAX_HEIGHT_MBS)) begin
                        n_err = ERR_OVERSIZE;  n_phase = PH_DONE;
                    end else begin
                        n_hu = v[HU_W-1:0];  n_phase = PH_FMO;
                    end
                end
                PH_FMO: begin
                    n_fonly = v[0];
                    h_mbs   = (CALC_W'(r_hu) + CALC_W'(1)) << (v[0] ? 0 : 1);
                    if (h_mbs > CALC_W'(MAX_HEIGHT_MBS)) begin
                        n_err = ERR_OVERSIZE;  n_phase = PH_DONE;
                    end else begin
                        n_phase = v[0] ? PH_D8 : PH_MBAFF;
                    end
                end
                PH_MBAFF: n_phase = PH_D8;
                PH_D8: begin
                    if (!r_fonly && v == 0) begin
                        n_err = ERR_D8;  n_phase = PH_DONE;
                    end else begin
                        n_phase = PH_CROP_FLAG;
                    end
                end
                PH_CROP_FLAG: n_phase = v[0] ? PH_CROP_L : PH_VUI;
                PH_CROP_L:    n_phase = PH_CROP_R;
                PH_CROP_R: begin
                    n_crop_r = (v > 65535) ? 16'hFFFF : v[15:0];
                    n_phase  = PH_CROP_T;
                end
                PH_CROP_T: n_phase = PH_CROP_B;
                PH_CROP_B: begin
                    n_crop_b = (v > 65535) ? 16'hFFFF : v[15:0];
                    n_phase  = PH_VUI;
                end
                PH_VUI:     n_phase = v[0] ? PH_AR_FLAG : PH_DONE;
                PH_AR_FLAG: n_phase = v[0] ? PH_AR_IDC : PH_DONE;
                PH_AR_IDC: begin
                    if (v < 14) begin
                        n_aw    = {8'd0, sar_w_lookup(v[3:0])};
                        n_ah    = {8'd0, sar_h_lookup(v[3:0])};
                        n_phase = PH_DONE;
                    end else if (v == 255) begin
                        n_phase = PH_SAR_W;
                    end else begin
                        n_phase = PH_DONE;
                    end
                end
                PH_SAR_W: begin
                    n_aw = v[15:0];  n_phase = PH_SAR_H;
                end
                PH_SAR_H: begin
                    n_ah = v[15:0];  n_phase = PH_DONE;
                end
                default: n_phase = PH_DONE;
            endcase
        end
    end

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= DEF_SKIP_BYTES;
        end else if (i_cfg_wen) begin
            r_cfg <= i_cfg_wdata;
        end
    end

    // per-unit parser state, cleared at reset and after each result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.emit) begin
            r_skip <= '0;  r_zrun <= '0;  r_phase <= PH_NAL;  r_lz <= '0;
            r_acc <= '0;  r_bcnt <= '0;  r_suf <= 1'b0;  r_list <= '0;
            r_entry <= '0;  r_last_sc <= 8'd8;  r_next_sc <= 8'd8;
            r_chroma <= 2'd1;  r_fonly <= 1'b0;  r_wu <= '0;  r_hu <= '0;
            r_crop_r <= '0;  r_crop_b <= '0;  r_prof <= '0;  r_lvl <= '0;
            r_aw <= 16'd1;  r_ah <= 16'd1;  r_err <= ERR_NONE;
        end else begin
            if (i_cmd.load) begin
                r_byte <= i_byte;
                if (skip_now) begin
                    r_skip <= r_skip + 3'd1;
                end else if (drop_now) begin
                    r_zrun <= 2'd0;
                end else if (i_byte == 8'd0) begin
                    r_zrun <= (r_zrun < 2'd2) ? r_zrun + 2'd1 : 2'd2;
                end else begin
                    r_zrun <= 2'd0;
                end
            end
            if (i_cmd.bit_en) begin
                r_phase <= n_phase;  r_lz <= n_lz;  r_acc <= n_acc;
                r_bcnt <= n_bcnt;  r_suf <= n_suf;  r_list <= n_list;
                r_entry <= n_entry;  r_last_sc <= n_last_sc;
                r_next_sc <= n_next_sc;  r_chroma <= n_chroma;
                r_fonly <= n_fonly;  r_wu <= n_wu;  r_hu <= n_hu;
                r_crop_r <= n_crop_r;  r_crop_b <= n_crop_b;  r_prof <= n_prof;
                r_lvl <= n_lvl;  r_aw <= n_aw;  r_ah <= n_ah;  r_err <= n_err;
            end
        end
    end

    // result computation
    logic [ERR_W-1:0]  res_code;
    logic [CALC_W-1:0] full_w;
    logic [CALC_W-1:0] full_h;
    logic [CALC_W-1:0] crop_w;
    logic [CALC_W-1:0] crop_h;
    logic [1:0]        crop_h_sh;
    logic [CALC_W-1:0] diff_w;
    logic [CALC_W-1:0] diff_h;

    always_comb begin
        if (r_err != ERR_NONE) begin
            res_code = r_err;
        end else if (r_phase != PH_DONE) begin
            res_code = ERR_TRUNC;
        end else begin
            res_code = ERR_NONE;
        end
        full_w    = (CALC_W'(r_wu) + CALC_W'(1)) << 4;
        full_h    = ((CALC_W'(r_hu) + CALC_W'(1)) << 4) << (r_fonly ? 0 : 1);
        crop_w    = CALC_W'(r_crop_r) << ((r_chroma == 2'd1 || r_chroma == 2'd2) ? 1 : 0);
        crop_h_sh = {1'b0, r_chroma == 2'd1} + {1'b0, !r_fonly};
        crop_h    = CALC_W'(r_crop_b) << crop_h_sh;
        diff_w    = (crop_w >= full_w) ? '0 : full_w - crop_w;
        diff_h    = (crop_h >= full_h) ? '0 : full_h - crop_h;
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_header_ok    <= (res_code == ERR_NONE);
            o_error_code   <= res_code;
            o_profile_code <= r_prof;
            o_level_code   <= r_lvl;
            if (res_code == ERR_NONE) begin
                o_frame_width   <= diff_w[WIDTH_W-1:0];
                o_frame_height  <= diff_h[HEIGHT_W-1:0];
                o_aspect_width  <= r_aw;
                o_aspect_height <= r_ah;
            end else begin
                o_frame_width   <= '0;
                o_frame_height  <= '0;
                o_aspect_width  <= 16'd1;
                o_aspect_height <= 16'd1;
            end
        end
    end

endmodule

@@ tb/sv/tb_h264_sps_header_parser.sv @@
`timescale 1ns / 1ps
module tb_h264_sps_header_parser;
    import hsps_pkg::*;

    localparam int MAX_W_MBS  = 1024;
    localparam int MAX_H_MBS  = 1024;
    localparam int IDLE_LIMIT = 3000;
    localparam int TARGET_BYTES = 1550;

    typedef enum int {
        PH_NAL, PH_PROFILE, PH_CONSTR, PH_LEVEL, PH_SPS_ID, PH_CHROMA, PH_SEP,
        PH_DEPTH_L, PH_DEPTH_C, PH_BYPASS, PH_SM_FLAG, PH_SL_FLAG, PH_DELTA,
        PH_FRAME_NUM, PH_POC_TYPE, PH_POC_LSB, PH_POC_ZERO, PH_POC_NONREF,
        PH_POC_TB, PH_POC_CYCLE, PH_POC_OFFSET, PH_REFS, PH_GAPS, PH_WIDTH,
        PH_HEIGHT, PH_FMO, PH_MBAFF, PH_D8, PH_CROP_FLAG, PH_CROP_L, PH_CROP_R,
        PH_CROP_T, PH_CROP_B, PH_VUI, PH_AR_FLAG, PH_AR_IDC, PH_SAR_W, PH_SAR_H,
        PH_DONE
    } t_sps_phase;

    typedef enum int {
        UNIT_GOOD, UNIT_BAD_FIELD, UNIT_NOISE, UNIT_CUT
    } t_unit_kind;

    typedef struct {
        bit          ok;
        logic [3:0]  err;
        logic [7:0]  prof;
        logic [7:0]  lvl;
        logic [14:0] fw;
        logic [15:0] fh;
        logic [15:0] aw;
        logic [15:0] ah;
    } t_sps_summary;

    // header parse tracker and expected summary store
    class sps_scoreboard;
        int unsigned skip_cfg;
        int unsigned skip_cnt, zrun, lz, bcnt;
        t_sps_phase  ph;
        bit          sfx;
        longint unsigned acc;
        int unsigned li, ei, last_sc, next_sc;
        int unsigned chroma, fonly, wu, hu, cr, cb;
        int unsigned prof, lvl, aw, ah, perr;
        t_sps_summary summaries[$];
        int errors;

        function new();
            skip_cfg = DEF_SKIP_BYTES;
            errors = 0;
            clear_unit();
        endfunction

        function void clear_unit();
            skip_cnt = 0; zrun = 0; ph = PH_NAL; lz = 0; acc = 0; bcnt = 0;
            sfx = 0; li = 0; ei = 0; last_sc = 8; next_sc = 8; chroma = 1;
            fonly = 0; wu = 0; hu = 0; cr = 0; cb = 0; prof = 0; lvl = 0;
            aw = 1; ah = 1; perr = 0;
        endfunction

        function int unsigned field_len(t_sps_phase p);
            case (p)
                PH_NAL, PH_PROFILE, PH_CONSTR, PH_LEVEL, PH_AR_IDC: return 8;
                PH_SAR_W, PH_SAR_H: return 16;
                PH_SEP, PH_BYPASS, PH_SM_FLAG, PH_SL_FLAG, PH_POC_ZERO, PH_GAPS,
                PH_FMO, PH_MBAFF, PH_D8, PH_CROP_FLAG, PH_VUI, PH_AR_FLAG:
                    return 1;
                default: return 0;
            endcase
        endfunction

        function void fail(logic [3:0] code);
            perr = code;
            ph = PH_DONE;
        endfunction

        function void next_list();
            li++;
            ph = (li < ((chroma != 3) ? 8 : 12)) ? PH_SL_FLAG : PH_FRAME_NUM;
        endfunction

        function void advance_entries();
            int unsigned size;
            size = (li < 6) ? 16 : 64;
            while (ei < size && next_sc == 0) ei++;
            if (ei >= size) next_list();
            else ph = PH_DELTA;
        endfunction

        // one decoded syntax element
        function void finish_field(longint unsigned v);
            longint unsigned mag;
            case (ph)
                PH_NAL: ph = PH_PROFILE;
                PH_PROFILE: begin
                    prof = v & 255;
                    if (!(v inside {66, 77, 88, 100, 110, 122, 244, 44})) fail(ERR_PROFILE);
                    else ph = PH_CONSTR;
                end
                PH_CONSTR: ph = PH_LEVEL;
                PH_LEVEL: begin
                    lvl = v & 255;
                    ph = PH_SPS_ID;
                end
                PH_SPS_ID: begin
                    if (v >= 32) fail(ERR_SPS_ID);
                    else if (prof >= 100 || prof == 44) ph = PH_CHROMA;
                    else begin
                        chroma = 1;
                        ph = PH_FRAME_NUM;
                    end
                end
                PH_CHROMA: begin
                    if (v > 3) fail(ERR_CHROMA);
                    else begin
                        chroma = v;
                        ph = (v == 3) ? PH_SEP : PH_DEPTH_L;
                    end
                end
                PH_SEP: ph = PH_DEPTH_L;
                PH_DEPTH_L: if (v > 4) fail(ERR_DEPTH); else ph = PH_DEPTH_C;
                PH_DEPTH_C: if (v > 4) fail(ERR_DEPTH); else ph = PH_BYPASS;
                PH_BYPASS: ph = PH_SM_FLAG;
                PH_SM_FLAG: begin
                    li = 0;
                    ph = v ? PH_SL_FLAG : PH_FRAME_NUM;
                end
                PH_SL_FLAG: begin
                    if (v) begin
                        ei = 0; last_sc = 8; next_sc = 8;
                        advance_entries();
                    end else next_list();
                end
                PH_DELTA: begin
                    mag = (v + 1) >> 1;
                    if (v & 1) next_sc = (last_sc + mag) & 255;
                    else next_sc = (last_sc - mag) & 255;
                    if (next_sc != 0) last_sc = next_sc;
                    ei++;
                    advance_entries();
                end
                PH_FRAME_NUM: if (v > 12) fail(ERR_FRAMENUM); else ph = PH_POC_TYPE;
                PH_POC_TYPE: begin
                    if (v > 2) fail(ERR_POC_TYPE);
                    else ph = (v == 0) ? PH_POC_LSB : (v == 1) ? PH_POC_ZERO : PH_REFS;
                end
                PH_POC_LSB: ph = PH_REFS;
                PH_POC_ZERO: ph = PH_POC_NONREF;
                PH_POC_NONREF: ph = PH_POC_TB;
                PH_POC_TB: ph = PH_POC_CYCLE;
                PH_POC_CYCLE: begin
                    if (v > 255) fail(ERR_POC_CYC);
                    else begin
                        ei = v;
                        ph = (ei != 0) ? PH_POC_OFFSET : PH_REFS;
                    end
                end
                PH_POC_OFFSET: begin
                    ei--;
                    if (ei == 0) ph = PH_REFS;
                end
                PH_REFS: if (v > 16) fail(ERR_REFS); else ph = PH_GAPS;
                PH_GAPS: ph = PH_WIDTH;
                PH_WIDTH: begin
                    if (v >= MAX_W_MBS) fail(ERR_OVERSIZE);
                    else begin
                        wu = v;
                        ph = PH_HEIGHT;
                    end
                end
                PH_HEIGHT: begin
                    if (v >= MAX_H_MBS) fail(ERR_OVERSIZE);
                    else begin
                        hu = v;
                        ph = PH_FMO;
                    end
                end
                PH_FMO: begin
                    fonly = v & 1;
                    if ((hu + 1) * (2 - fonly) > MAX_H_MBS) fail(ERR_OVERSIZE);
                    else ph = fonly ? PH_D8 : PH_MBAFF;
                end
                PH_MBAFF: ph = PH_D8;
                PH_D8: if (!fonly && v == 0) fail(ERR_D8); else ph = PH_CROP_FLAG;
                PH_CROP_FLAG: ph = v ? PH_CROP_L : PH_VUI;
                PH_CROP_L: ph = PH_CROP_R;
                PH_CROP_R: begin
                    cr = (v > 65535) ? 65535 : v;
                    ph = PH_CROP_T;
                end
                PH_CROP_T: ph = PH_CROP_B;
                PH_CROP_B: begin
                    cb = (v > 65535) ? 65535 : v;
                    ph = PH_VUI;
                end
                PH_VUI: ph = v ? PH_AR_FLAG : PH_DONE;
                PH_AR_FLAG: ph = v ? PH_AR_IDC : PH_DONE;
                PH_AR_IDC: begin
                    if (v < 14) begin
                        aw = sar_w_lookup(v[3:0]);
                        ah = sar_h_lookup(v[3:0]);
                        ph = PH_DONE;
                    end else ph = (v == 255) ? PH_SAR_W : PH_DONE;
                end
                PH_SAR_W: begin
                    aw = v & 16'hFFFF;
                    ph = PH_SAR_H;
                end
                PH_SAR_H: begin
                    ah = v & 16'hFFFF;
                    ph = PH_DONE;
                end
                default: ph = PH_DONE;
            endcase
        endfunction

        // bit-serial field sequencer
        function void take_bit(bit b);
            int unsigned len;
            longint unsigned v;
            if (ph >= PH_DONE) return;
            len = field_len(ph);
            if (len == 0) begin
                if (!sfx) begin
                    if (b == 0) begin
                        if (lz < 32) lz++;
                        return;
                    end
                    sfx = 1; acc = 1; bcnt = lz;
                end else begin
                    acc = ((acc << 1) | b) & 64'h1_FFFF_FFFF;
                    bcnt--;
                end
                if (bcnt != 0) return;
                v = acc - 1;
            end else begin
                acc = ((acc << 1) | b) & 64'h1_FFFF_FFFF;
                bcnt++;
                if (bcnt < len) return;
                v = acc;
            end
            acc = 0; bcnt = 0; lz = 0; sfx = 0;
            finish_field(v);
        endfunction

        // accepted input byte
        function void note_byte(logic [7:0] b, bit last);
            t_sps_summary s;
            int unsigned cx, cy;
            longint unsigned w, h, cw, ch;
            if (skip_cnt < skip_cfg) skip_cnt++;
            else if (zrun >= 2 && b == 8'h03) zrun = 0;
            else begin
                zrun = (b == 0) ? ((zrun < 2) ? zrun + 1 : 2) : 0;
                for (int k = 7; k >= 0; k--) take_bit(b[k]);
            end
            if (!last) return;
            s.err = perr;
            if (s.err == ERR_NONE && ph != PH_DONE) s.err = ERR_TRUNC;
            s.ok = (s.err == ERR_NONE);
            s.prof = prof;
            s.lvl = lvl;
            if (s.ok) begin
                cx = (chroma == 1 || chroma == 2) ? 2 : 1;
                cy = ((chroma == 1) ? 2 : 1) * (2 - fonly);
                w = (wu + 1) * 16;
                h = (hu + 1) * 16 * (2 - fonly);
                cw = cx * cr;
                ch = cy * cb;
                s.fw = (cw >= w) ? 0 : (w - cw);
                s.fh = (ch >= h) ? 0 : (h - ch);
                s.aw = aw;
                s.ah = ah;
            end else begin
                s.fw = 0; s.fh = 0; s.aw = 1; s.ah = 1;
            end
            summaries.push_back(s);
            clear_unit();
        endfunction

        function void cmp(string name, longint unsigned exp_v, longint unsigned act_v);
            if (exp_v != act_v) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name,
                         exp_v, act_v);
                errors++;
            end
        endfunction

        // accepted result transaction
        function void check_result(logic [87:0] d, logic u);
            t_sps_summary s;
            if (summaries.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, d);
                errors++;
                return;
            end
            s = summaries.pop_front();
            cmp("header_ok", s.ok, u);
            cmp("error_code", s.err, d[3:0]);
            cmp("profile_code", s.prof, d[11:4]);
            cmp("level_code", s.lvl, d[19:12]);
            cmp("frame_width", s.fw, d[34:20]);
            cmp("frame_height", s.fh, d[50:35]);
            cmp("aspect_width", s.aw, d[66:51]);
            cmp("aspect_height", s.ah, d[82:67]);
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n;
    logic        i_cfg_wen;
    logic [2:0]  i_cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [87:0] m_axis_tdata;
    logic        m_axis_tuser;

    sps_scoreboard sb = new();
    bit  calm;
    int  bytes_sent;
    int  idle_cycles;
    bit  bq[$];
    logic [7:0] nal[$];

    h264_sps_header_parser DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wen     (i_cfg_wen),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    // transaction monitors and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready) sb.note_byte(s_axis_tdata, s_axis_tlast);
        if (i_rst_n && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tuser);
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb_h264_sps_header_parser NOT OK");
            $finish;
        end
    end

    // result receiver with random stalls
    initial begin
        int gap;
        forever begin
            gap = calm ? 0 : $urandom_range(7, 0);
            if (gap != 0) begin
                m_axis_tready <= 0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1;
            do @(posedge i_clk); while (!(m_axis_tvalid && i_rst_n));
        end
    end

    task automatic send_byte(logic [7:0] b, bit last);
        int gap;
        gap = calm ? 0 : $urandom_range(7, 0);
        if (gap != 0) begin
            s_axis_tvalid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata <= b;
        s_axis_tlast <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        bytes_sent++;
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 0;
        while (sb.summaries.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_skip(logic [2:0] v);
        wait_drained();
        i_cfg_wen <= 1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_wen <= 0;
        sb.skip_cfg = v;
    endtask

    task automatic put_bits(longint unsigned v, int n);
        for (int i = n - 1; i >= 0; i--) bq.push_back(v[i]);
    endtask

    task automatic put_ue(longint unsigned v);
        longint unsigned code;
        int n;
        code = v + 1;
        n = 0;
        while ((code >> (n + 1)) != 0) n++;
        put_bits(0, n);
        put_bits(code, n + 1);
    endtask

    task automatic put_se(int d);
        put_ue(d > 0 ? 2 * d - 1 : -2 * d);
    endtask

    // syntax elements of one header, optionally with one field out of range
    task automatic build_header(bit bad);
        int err, pr, ch, fo, idc, lists, size, last_v, next_v, d, cyc;
        int profiles[8] = '{66, 77, 88, 100, 110, 122, 244, 44};
        err = bad ? $urandom_range(10, 1) : 0;
        put_bits($urandom_range(255, 0), 8);
        pr = profiles[$urandom_range(7, 0)];
        if (err == 1) begin
            pr = $urandom_range(255, 0);
            if (pr inside {66, 77, 88, 100, 110, 122, 244, 44}) pr = 0;
        end
        put_bits(pr, 8);
        put_bits($urandom_range(255, 0), 8);
        put_bits($urandom_range(255, 0), 8);
        if (err == 2 && $urandom_range(1, 0)) begin
            // code with more than 32 leading zeros
            put_bits(0, $urandom_range(40, 33));
            put_bits(1, 1);
            put_bits({$urandom, $urandom}, 32);
        end else put_ue(err == 2 ? $urandom_range(300, 32) : $urandom_range(31, 0));
        if (pr >= 100 || pr == 44) begin
            ch = (err == 3) ? $urandom_range(10, 4) : $urandom_range(3, 0);
            put_ue(ch);
            if (ch == 3) put_bits($urandom_range(1, 0), 1);
            put_ue(err == 4 ? $urandom_range(9, 5) : $urandom_range(4, 0));
            put_ue($urandom_range(4, 0));
            put_bits($urandom_range(1, 0), 1);
            if ($urandom_range(2, 0) == 0) begin
                put_bits(1, 1);
                lists = (ch != 3) ? 8 : 12;
                for (int l = 0; l < lists; l++) begin
                    if ($urandom_range(1, 0)) begin
                        put_bits(1, 1);
                        size = (l < 6) ? 16 : 64;
                        last_v = 8;
                        for (int e = 0; e < size; e++) begin
                            case ($urandom_range(5, 0))
                                0:       d = -last_v;
                                1:       d = $urandom_range(255, 0) - 128;
                                default: d = $urandom_range(16, 0) - 8;
                            endcase
                            put_se(d);
                            next_v = (last_v + d) & 255;
                            if (next_v == 0) break;
                            last_v = next_v;
                        end
                    end else put_bits(0, 1);
                end
            end else put_bits(0, 1);
        end
        put_ue(err == 5 ? $urandom_range(40, 13) : $urandom_range(12, 0));
        d = (err == 6) ? $urandom_range(9, 3) : $urandom_range(2, 0);
        put_ue(d);
        if (d == 0) put_ue($urandom_range(12, 0));
        else if (d == 1) begin
            put_bits($urandom_range(1, 0), 1);
            put_se($urandom_range(200, 0) - 100);
            put_se($urandom_range(200, 0) - 100);
            cyc = (err == 7) ? $urandom_range(400, 256) : $urandom_range(5, 0);
            put_ue(cyc);
            if (err != 7) for (int c = 0; c < cyc; c++) put_se($urandom_range(64, 0) - 32);
        end
        put_ue(err == 8 ? $urandom_range(30, 17) : $urandom_range(16, 0));
        put_bits($urandom_range(1, 0), 1);
        if (err == 10 && $urandom_range(1, 0)) put_ue($urandom_range(1100, 1024));
        else put_ue($urandom_range(3, 0) == 0 ? $urandom_range(1023, 0) : $urandom_range(20, 0));
        if (err == 10) put_ue($urandom_range(1, 0) ? $urandom_range(1100, 1024)
                                                   : $urandom_range(1023, 512));
        else put_ue($urandom_range(3, 0) == 0 ? $urandom_range(1023, 0)
                                              : $urandom_range(20, 0));
        fo = (err == 10) ? 0 : $urandom_range(1, 0);
        put_bits(fo, 1);
        if (!fo) put_bits($urandom_range(1, 0), 1);
        put_bits((err == 9) ? 0 : (fo ? $urandom_range(1, 0) : 1), 1);
        if ($urandom_range(1, 0)) begin
            put_bits(1, 1);
            for (int c = 0; c < 4; c++)
                put_ue($urandom_range(7, 0) == 0 ? $urandom_range(100000, 0)
                                                 : $urandom_range(20, 0));
        end else put_bits(0, 1);
        if ($urandom_range(3, 0) != 0) begin
            put_bits(1, 1);
            if ($urandom_range(3, 0) != 0) begin
                put_bits(1, 1);
                case ($urandom_range(3, 0))
                    0:       idc = 255;
                    1:       idc = $urandom_range(255, 0);
                    default: idc = $urandom_range(16, 0);
                endcase
                put_bits(idc, 8);
                if (idc == 255) begin
                    put_bits($urandom_range(65535, 0), 16);
                    put_bits($urandom_range(65535, 0), 16);
                end
            end else put_bits(0, 1);
        end else put_bits(0, 1);
        // trailing vui bits, stop bit and alignment
        put_bits($urandom, $urandom_range(20, 0));
        put_bits(1, 1);
        while (bq.size() % 8 != 0) bq.push_back(0);
    endtask

    // build, escape and send one NAL unit
    task automatic send_unit(t_unit_kind kind);
        logic [7:0] b;
        int zeros, cut, len;
        bq.delete();
        nal.delete();
        if (kind == UNIT_NOISE) begin
            len = $urandom_range(12, 1);
            for (int i = 0; i < len; i++) begin
                case ($urandom_range(3, 0))
                    0:       nal.push_back(8'h00);
                    1:       nal.push_back(8'h03);
                    default: nal.push_back($urandom_range(255, 0));
                endcase
            end
        end else begin
            build_header(kind == UNIT_BAD_FIELD);
            zeros = 0;
            for (int i = 0; i < bq.size(); i += 8) begin
                for (int k = 0; k < 8; k++) b[7 - k] = bq[i + k];
                if (zeros >= 2 && b <= 8'h03) begin
                    nal.push_back(8'h03);
                    zeros = 0;
                end
                nal.push_back(b);
                zeros = (b == 0) ? zeros + 1 : 0;
            end
            if (kind == UNIT_CUT) begin
                cut = $urandom_range(nal.size(), 1);
                repeat (cut) void'(nal.pop_back());
            end
        end
        for (int i = 0; i < sb.skip_cfg; i++) nal.push_front($urandom_range(255, 0));
        if (nal.size() == 0) nal.push_back($urandom_range(255, 0));
        for (int i = 0; i < nal.size(); i++) send_byte(nal[i], i == nal.size() - 1);
    endtask

    task automatic random_unit();
        int r;
        r = $urandom_range(9, 0);
        if (r < 6) send_unit(UNIT_GOOD);
        else if (r < 8) send_unit(UNIT_BAD_FIELD);
        else if (r == 8) send_unit(UNIT_CUT);
        else send_unit(UNIT_NOISE);
    endtask

    initial begin
        logic [2:0] skip_plan[6] = '{3'd0, 3'd4, 3'd1, 3'd2, 3'd3, 3'd0};
        i_rst_n <= 0;
        i_cfg_wen <= 0;
        i_cfg_wdata <= 0;
        s_axis_tvalid <= 0;
        s_axis_tdata <= 0;
        s_axis_tlast <= 0;
        calm = 0;
        bytes_sent = 0;
        idle_cycles = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: unit ending inside the start code, then a clean header
        send_byte(8'h00, 0);
        send_byte(8'h00, 1);
        send_unit(UNIT_GOOD);
        wait_drained();
        // directed: escaped byte carrying the last marker, then zero bytes closed by 0xFF
        write_skip(3'd0);
        send_byte(8'h00, 0);
        send_byte(8'h00, 0);
        send_byte(8'h03, 1);
        for (int i = 0; i < 8; i++) send_byte(8'h00, 0);
        send_byte(8'hFF, 0);
        send_byte(8'hFF, 1);
        send_unit(UNIT_BAD_FIELD);

        // random phases over several start-code lengths
        for (int p = 0; p < 6; p++) begin
            write_skip(p == 5 ? 3'($urandom_range(4, 0)) : skip_plan[p]);
            calm = (p == 2);
            while (bytes_sent < (p + 1) * TARGET_BYTES / 6) begin
                random_unit();
                if ($urandom_range(15, 0) == 0) wait_drained();
            end
        end

        s_axis_tvalid <= 0;
        while (sb.summaries.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
        if (sb.errors == 0 && sb.summaries.size() == 0)
            $display("tb_h264_sps_header_parser OK");
        else
            $display("tb_h264_sps_header_parser NOT OK");
        $finish;
    end

endmodule
